### hdl/cubic_bspline_tessellator_macros.svh
// Assertion macros for the cubic B-spline tessellator.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef CUBIC_BSPLINE_TESSELLATOR_MACROS_SVH
`define CUBIC_BSPLINE_TESSELLATOR_MACROS_SVH
`ifndef SYNTH
`define CBT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cbt check failed");
`define CBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cbt check failed");
`else
`define CBT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CBT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/cbt_pkg.sv
// Shared constants and types for the cubic B-spline tessellator.
// No dependencies.
`default_nettype none
package cbt_pkg;
	localparam int STEPS_W = 6;
	localparam logic [STEPS_W-1:0] STEPS_MAX = 6'd32;
	localparam logic [STEPS_W-1:0] STEPS_RESET = 6'd10;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	// register index taken from paddr[2]
	localparam logic REG_SEGMENT_STEPS = 1'b0;
	// weight arithmetic widths, steps <= 32
	localparam int NSQ_W = 11;
	localparam int NCB_W = 16;
	localparam int DEN_W = 18;
	localparam int WS_W = 20;

	typedef enum logic {
		JOB_PRIME,
		JOB_SEGMENT
	} job_kind_t;
endpackage
`default_nettype wire

### hdl/cbt_point_if.sv
// Control point channel: valid/ready handshake plus point payload.
// No dependencies.
`default_nettype none
interface cbt_point_if #(parameter int COORD_BITS = 16);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic start_curve;
	modport source(output valid, point_x, point_y, start_curve, input ready);
	modport sink(input valid, point_x, point_y, start_curve, output ready);
endinterface
`default_nettype wire

### hdl/cbt_line_if.sv
// Line channel: valid/ready handshake plus line segment payload.
// No dependencies.
`default_nettype none
interface cbt_line_if #(parameter int COORD_BITS = 16);
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] line_x0;
	logic signed [COORD_BITS-1:0] line_y0;
	logic signed [COORD_BITS-1:0] line_x1;
	logic signed [COORD_BITS-1:0] line_y1;
	logic last_line;
	modport source(output valid, line_x0, line_y0, line_x1, line_y1, last_line, input ready);
	modport sink(input valid, line_x0, line_y0, line_x1, line_y1, last_line, output ready);
endinterface
`default_nettype wire

### hdl/cbt_front.sv
// Front end: accepts control points, keeps the three-point window and
// issues evaluation jobs. Depends on cbt_pkg and cbt_point_if.
`default_nettype none
module cbt_front #(
	parameter int COORD_BITS = 16,
	parameter int JOB_W = 1 + cbt_pkg::STEPS_W + 8 * COORD_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cbt_point_if.sink points,
	input  wire logic [cbt_pkg::STEPS_W-1:0] steps,
	output logic push,
	output logic [JOB_W-1:0] push_data,
	input  wire logic full
);
	logic signed [COORD_BITS-1:0] win_x_q [3];
	logic signed [COORD_BITS-1:0] win_y_q [3];
	logic [1:0] seen_q;
	logic [1:0] seen_eff;
	logic accept;
	logic [cbt_pkg::STEPS_W-1:0] n_eff;
	logic [3:0][COORD_BITS-1:0] jx;
	logic [3:0][COORD_BITS-1:0] jy;
	cbt_pkg::job_kind_t kind;

	assign points.ready = !full;
	assign accept = points.valid && !full;
	assign seen_eff = points.start_curve ? 2'd0 : seen_q;

	always_comb begin
		if (steps == '0) begin
			n_eff = cbt_pkg::STEPS_W'(1);
		end else if (steps > cbt_pkg::STEPS_MAX) begin
			n_eff = cbt_pkg::STEPS_MAX;
		end else begin
			n_eff = steps;
		end
	end

	always_comb begin
		jx[0] = win_x_q[0];
		jy[0] = win_y_q[0];
		jx[1] = win_x_q[1];
		jy[1] = win_y_q[1];
		if (seen_eff == 2'd3) begin
			kind = cbt_pkg::JOB_SEGMENT;
			jx[2] = win_x_q[2];
			jy[2] = win_y_q[2];
			jx[3] = points.point_x;
			jy[3] = points.point_y;
		end else begin
			// third point of a curve: prime prev with the t=0 sample
			kind = cbt_pkg::JOB_PRIME;
			jx[2] = points.point_x;
			jy[2] = points.point_y;
			jx[3] = '0;
			jy[3] = '0;
		end
	end

	assign push = accept && (seen_eff == 2'd2 || seen_eff == 2'd3);
	assign push_data = {kind, n_eff, jx, jy};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			for (int i = 0; i < 3; i++) begin
				win_x_q[i] <= '0;
				win_y_q[i] <= '0;
			end
		end else if (accept) begin
			if (seen_eff == 2'd3) begin
				win_x_q[0] <= win_x_q[1];
				win_y_q[0] <= win_y_q[1];
				win_x_q[1] <= win_x_q[2];
				win_y_q[1] <= win_y_q[2];
				win_x_q[2] <= points.point_x;
				win_y_q[2] <= points.point_y;
			end else begin
				win_x_q[seen_eff] <= points.point_x;
				win_y_q[seen_eff] <= points.point_y;
				seen_q <= seen_eff + 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

### hdl/cbt_queue.sv
// Two-entry job queue between the front end and the evaluator.
// No dependencies.
`default_nettype none
module cbt_queue #(
	parameter int W = 136
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire logic [W-1:0] push_data,
	output logic full,
	input  wire logic pop,
	output logic [W-1:0] pop_data,
	output logic empty
);
	logic [W-1:0] mem_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

### hdl/cbt_div.sv
// Four-lane restoring divider: q = (w * 2^T + den/2) / den, one bit per cycle.
// Depends on cbt_pkg.
`default_nettype none
module cbt_div #(
	parameter int T_FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [cbt_pkg::DEN_W-1:0] den,
	input  wire logic [3:0][cbt_pkg::DEN_W-1:0] w,
	output logic busy,
	output logic [3:0][T_FRAC_BITS-1:0] q
);
	localparam int NB = cbt_pkg::DEN_W + 1 + T_FRAC_BITS;
	localparam int RW = cbt_pkg::DEN_W + 1;
	localparam int CW = $clog2(T_FRAC_BITS + 1);

	logic [RW-1:0] rem_q [4];
	logic [T_FRAC_BITS-1:0] lo_q [4];
	logic [T_FRAC_BITS-1:0] quo_q [4];
	logic [cbt_pkg::DEN_W-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [NB-1:0] num [4];
	logic [RW-1:0] shifted [4];
	logic [RW-1:0] diff [4];
	logic take [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			num[i] = (NB'(w[i]) << T_FRAC_BITS) + NB'(den >> 1);
			shifted[i] = {rem_q[i][RW-2:0], lo_q[i][T_FRAC_BITS-1]};
			take[i] = shifted[i] >= RW'(den_q);
			diff[i] = shifted[i] - RW'(den_q);
			q[i] = quo_q[i];
		end
	end

	assign busy = busy_q;

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			for (int i = 0; i < 4; i++) begin
				// quotient stays below 2^T, so the top part is already below den
				rem_q[i] <= num[i][NB-1:T_FRAC_BITS];
				lo_q[i] <= num[i][T_FRAC_BITS-1:0];
				quo_q[i] <= '0;
			end
		end else if (busy_q) begin
			for (int i = 0; i < 4; i++) begin
				rem_q[i] <= take[i] ? diff[i] : shifted[i];
				lo_q[i] <= lo_q[i] << 1;
				quo_q[i] <= {quo_q[i][T_FRAC_BITS-2:0], take[i]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(T_FRAC_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

### hdl/cbt_back.sv
// Evaluator: per sample forms the cubic weights, runs them through the
// divider, does eight MACs on one multiplier and emits the line item;
// prime jobs only set prev. Depends on cbt_pkg and cbt_line_if.
`default_nettype none
module cbt_back #(
	parameter int COORD_BITS = 16,
	parameter int T_FRAC_BITS = 16,
	parameter int JOB_W = 1 + cbt_pkg::STEPS_W + 8 * COORD_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic job_valid,
	input  wire logic [JOB_W-1:0] job_data,
	output logic pop,
	output logic div_start,
	output logic [cbt_pkg::DEN_W-1:0] div_den,
	output logic [3:0][cbt_pkg::DEN_W-1:0] div_w,
	input  wire logic div_busy,
	input  wire logic [3:0][T_FRAC_BITS-1:0] div_q,
	cbt_line_if.source lines
);
	localparam int C = COORD_BITS;
	localparam int T = T_FRAC_BITS;
	localparam int SW = cbt_pkg::STEPS_W;
	localparam int PROD_W = T + 1 + C;
	localparam int ACC_W = C + T + 3;
	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< (T - 1));
	localparam logic signed [ACC_W-1:0] CMAX = ACC_W'((64'sd1 <<< (C - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] CMIN = ACC_W'(-(64'sd1 <<< (C - 1)));

	typedef enum logic [3:0] {
		ST_IDLE, ST_N2, ST_N3, ST_DEN, ST_W1, ST_W2, ST_W3, ST_DIV, ST_MAC, ST_EMIT
	} state_t;

	state_t state_q;
	logic kind_raw;
	cbt_pkg::job_kind_t kind_w;
	logic [SW-1:0] n_w;
	logic [3:0][C-1:0] jx_w;
	logic [3:0][C-1:0] jy_w;

	cbt_pkg::job_kind_t kind_q;
	logic [SW-1:0] n_q, u_q, d_q;
	logic signed [C-1:0] px_q [4];
	logic signed [C-1:0] py_q [4];
	logic [cbt_pkg::NSQ_W-1:0] n2_q, u2_q, d2_q;
	logic [cbt_pkg::NCB_W-1:0] n3_q, un2_q, u3_q, u2n_q, d3_q;
	logic [cbt_pkg::DEN_W-1:0] den_q;
	logic [3:0] m_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic prod_y_s1;
	logic prod_v_s1;
	logic signed [ACC_W-1:0] accx_q, accy_q;
	logic signed [C-1:0] prev_x_q, prev_y_q;
	logic out_valid_q;
	logic signed [C-1:0] ox0_q, oy0_q, ox1_q, oy1_q;
	logic olast_q;

	logic [cbt_pkg::WS_W-1:0] w1_full, w2_full;
	logic [1:0] sel;
	logic signed [C-1:0] coord;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0] rx, ry, shx, shy;
	logic signed [C-1:0] cx, cy;
	logic out_free;
	logic emit;

	assign {kind_raw, n_w, jx_w, jy_w} = job_data;
	assign kind_w = cbt_pkg::job_kind_t'(kind_raw);
	assign pop = state_q == ST_IDLE && job_valid;
	assign div_start = state_q == ST_W3;
	assign div_den = den_q;

	always_comb begin
		w1_full = cbt_pkg::WS_W'(u3_q) * cbt_pkg::WS_W'(3) + (cbt_pkg::WS_W'(n3_q) << 2)
			- cbt_pkg::WS_W'(u2n_q) * cbt_pkg::WS_W'(6);
		w2_full = (cbt_pkg::WS_W'(u2n_q) + cbt_pkg::WS_W'(un2_q)) * cbt_pkg::WS_W'(3)
			+ cbt_pkg::WS_W'(n3_q) - cbt_pkg::WS_W'(u3_q) * cbt_pkg::WS_W'(3);
		div_w[0] = cbt_pkg::DEN_W'(d3_q);
		div_w[1] = w1_full[cbt_pkg::DEN_W-1:0];
		div_w[2] = w2_full[cbt_pkg::DEN_W-1:0];
		div_w[3] = cbt_pkg::DEN_W'(u3_q);
	end

	always_comb begin
		sel = m_q[1:0];
		coord = m_q[2] ? py_q[sel] : px_q[sel];
		prod = $signed({1'b0, div_q[sel]}) * coord;
	end

	// round half up (floor after adding one half), then saturate
	always_comb begin
		rx = accx_q + HALF;
		ry = accy_q + HALF;
		shx = rx >>> T;
		shy = ry >>> T;
		if (shx > CMAX) begin
			cx = CMAX[C-1:0];
		end else if (shx < CMIN) begin
			cx = CMIN[C-1:0];
		end else begin
			cx = shx[C-1:0];
		end
		if (shy > CMAX) begin
			cy = CMAX[C-1:0];
		end else if (shy < CMIN) begin
			cy = CMIN[C-1:0];
		end else begin
			cy = shy[C-1:0];
		end
	end

	assign out_free = !out_valid_q || lines.ready;
	assign emit = state_q == ST_EMIT && kind_q == cbt_pkg::JOB_SEGMENT && out_free;
	assign lines.valid = out_valid_q;
	assign lines.line_x0 = ox0_q;
	assign lines.line_y0 = oy0_q;
	assign lines.line_x1 = ox1_q;
	assign lines.line_y1 = oy1_q;
	assign lines.last_line = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q <= cbt_pkg::JOB_PRIME;
			n_q <= '0;
			u_q <= '0;
			d_q <= '0;
			m_q <= '0;
			for (int i = 0; i < 4; i++) begin
				px_q[i] <= '0;
				py_q[i] <= '0;
			end
			n2_q <= '0;
			u2_q <= '0;
			d2_q <= '0;
			n3_q <= '0;
			un2_q <= '0;
			u3_q <= '0;
			u2n_q <= '0;
			d3_q <= '0;
			den_q <= '0;
			prod_s1 <= '0;
			prod_v_s1 <= 1'b0;
			prod_y_s1 <= 1'b0;
			accx_q <= '0;
			accy_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			out_valid_q <= 1'b0;
			ox0_q <= '0;
			oy0_q <= '0;
			ox1_q <= '0;
			oy1_q <= '0;
			olast_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (lines.ready) begin
				out_valid_q <= 1'b0;
			end
			if (prod_v_s1) begin
				if (prod_y_s1) begin
					accy_q <= accy_q + ACC_W'(prod_s1);
				end else begin
					accx_q <= accx_q + ACC_W'(prod_s1);
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						kind_q <= kind_w;
						n_q <= n_w;
						u_q <= '0;
						for (int i = 0; i < 4; i++) begin
							px_q[i] <= jx_w[i];
							py_q[i] <= jy_w[i];
						end
						state_q <= ST_N2;
					end
				end
				ST_N2: begin
					n2_q <= cbt_pkg::NSQ_W'(n_q) * cbt_pkg::NSQ_W'(n_q);
					state_q <= ST_N3;
				end
				ST_N3: begin
					n3_q <= cbt_pkg::NCB_W'(n2_q) * cbt_pkg::NCB_W'(n_q);
					state_q <= ST_DEN;
				end
				ST_DEN: begin
					den_q <= (cbt_pkg::DEN_W'(n3_q) << 2) + (cbt_pkg::DEN_W'(n3_q) << 1);
					state_q <= ST_W1;
				end
				ST_W1: begin
					u2_q <= cbt_pkg::NSQ_W'(u_q) * cbt_pkg::NSQ_W'(u_q);
					d2_q <= cbt_pkg::NSQ_W'(n_q - u_q) * cbt_pkg::NSQ_W'(n_q - u_q);
					d_q <= n_q - u_q;
					un2_q <= cbt_pkg::NCB_W'(u_q) * cbt_pkg::NCB_W'(n2_q);
					state_q <= ST_W2;
				end
				ST_W2: begin
					u3_q <= cbt_pkg::NCB_W'(u2_q) * cbt_pkg::NCB_W'(u_q);
					u2n_q <= cbt_pkg::NCB_W'(u2_q) * cbt_pkg::NCB_W'(n_q);
					d3_q <= cbt_pkg::NCB_W'(d2_q) * cbt_pkg::NCB_W'(d_q);
					state_q <= ST_W3;
				end
				ST_W3: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!div_busy) begin
						m_q <= '0;
						accx_q <= '0;
						accy_q <= '0;
						prod_v_s1 <= 1'b0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (!m_q[3]) begin
						prod_s1 <= prod;
						prod_y_s1 <= m_q[2];
						prod_v_s1 <= 1'b1;
						m_q <= m_q + 4'd1;
					end else begin
						prod_v_s1 <= 1'b0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (kind_q == cbt_pkg::JOB_PRIME) begin
						prev_x_q <= cx;
						prev_y_q <= cy;
						state_q <= ST_IDLE;
					end else if (out_free) begin
						ox0_q <= prev_x_q;
						oy0_q <= prev_y_q;
						ox1_q <= cx;
						oy1_q <= cy;
						olast_q <= u_q == n_q;
						prev_x_q <= cx;
						prev_y_q <= cy;
						if (u_q == n_q) begin
							state_q <= ST_IDLE;
						end else begin
							u_q <= u_q + SW'(1);
							state_q <= ST_W1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

### hdl/cubic_bspline_tessellator.sv
// Uniform cubic B-spline tessellator: a stream of control points in,
// a stream of line items out.
//
// points: one control point per item (point_x, point_y, start_curve).
//   start_curve drops the stored points. The first three points of a curve
//   are stored; the third also seeds the previous curve point. Every later
//   point closes a segment and yields segment_steps+1 line items.
// lines: line items from the previous to the current rounded curve point;
//   last_line marks the final item of a segment.
// APB register 0 (segment_steps, reset 10): 0 acts as 1, above 32 as 32.
// Per sample the evaluator runs weight setup, the divider, the
//   multiply-accumulates and the emit step. The segment rate is set by
//   the bit-serial divider and the single multiplier.
//   The first two points of a curve push no job; like every point they
//   wait while the job queue is full.
// A two-item job queue lets points be taken while a segment is evaluated.
// A stalled receiver holds the output register and halts evaluation.
// Reset clears the window, the previous point, the queue and all valids.
// Depends on cbt_pkg, cbt_point_if, cbt_line_if and the submodules.
`default_nettype none
`include "cubic_bspline_tessellator_macros.svh"
module cubic_bspline_tessellator #(
	parameter int COORD_BITS = 16,
	parameter int T_FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cbt_point_if.sink points,
	cbt_line_if.source lines,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [cbt_pkg::PADDR_W-1:0] paddr,
	input  wire logic [cbt_pkg::PDATA_W-1:0] pwdata,
	output logic [cbt_pkg::PDATA_W-1:0] prdata,
	output logic pready
);
	localparam int JOB_W = 1 + cbt_pkg::STEPS_W + 8 * COORD_BITS;

	logic [cbt_pkg::STEPS_W-1:0] steps_q;
	logic q_push, q_full, q_pop, q_empty;
	logic [JOB_W-1:0] q_wdata, q_rdata;
	logic div_start, div_busy;
	logic [cbt_pkg::DEN_W-1:0] div_den;
	logic [3:0][cbt_pkg::DEN_W-1:0] div_w;
	logic [3:0][T_FRAC_BITS-1:0] div_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == cbt_pkg::REG_SEGMENT_STEPS)
		? cbt_pkg::PDATA_W'(steps_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= cbt_pkg::STEPS_RESET;
		end else if (psel && penable && pwrite && paddr[2] == cbt_pkg::REG_SEGMENT_STEPS) begin
			steps_q <= pwdata[cbt_pkg::STEPS_W-1:0];
		end
	end

	cbt_front #(.COORD_BITS(COORD_BITS), .JOB_W(JOB_W)) u_front (
		.clk(clk), .arst_n(arst_n), .points(points), .steps(steps_q),
		.push(q_push), .push_data(q_wdata), .full(q_full)
	);

	cbt_queue #(.W(JOB_W)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_data(q_wdata), .full(q_full),
		.pop(q_pop), .pop_data(q_rdata), .empty(q_empty)
	);

	cbt_div #(.T_FRAC_BITS(T_FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .den(div_den), .w(div_w),
		.busy(div_busy), .q(div_q)
	);

	cbt_back #(.COORD_BITS(COORD_BITS), .T_FRAC_BITS(T_FRAC_BITS), .JOB_W(JOB_W)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(!q_empty), .job_data(q_rdata), .pop(q_pop),
		.div_start(div_start), .div_den(div_den), .div_w(div_w), .div_busy(div_busy),
		.div_q(div_q), .lines(lines)
	);

	`CBT_ASSERT_NOW(a_no_push_full, clk, arst_n, q_push, !q_full)
	`CBT_ASSERT_NOW(a_no_pop_empty, clk, arst_n, q_pop, !q_empty)
	`CBT_ASSERT_NOW(a_div_idle_start, clk, arst_n, div_start, !div_busy)
	`CBT_ASSERT_NEXT(a_div_runs, clk, arst_n, div_start, div_busy)
endmodule
`default_nettype wire
